### src/assert_macros.svh
// Assertion helpers shared by the RTL; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every edge outside reset.
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Property checked at every edge, reset included.
`define ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALL(label, clk, prop)
`endif
`endif

### src/abmdc_pkg.sv
package abmdc_pkg;

  localparam int BIN_COUNT     = 3600;
  localparam int QUALITY_SHIFT = 2;

  localparam int BIN_W  = $clog2(BIN_COUNT);
  localparam int CNT_W  = $clog2(BIN_COUNT + 1);
  localparam int DIST_W = 31;

  localparam logic [DIST_W-1:0] NO_READING = {DIST_W{1'b1}};
  localparam logic [15:0]       SCAN_LIMIT_RST = 16'd100;
  localparam logic [15:0]       SCANS_MAX = 16'hFFFF;

  // Angle to bin: round(angle * 900 / 2^14), halves up
  localparam int ANGLE_SCALE = 900;
  localparam int FRAC_BITS   = 14;
  localparam int PROD_W      = 26;

  typedef enum logic [1:0] {
    FUNC_MEAS = 2'd0,
    FUNC_SCAN = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CAUSE_RUNNING = 2'd0,
    CAUSE_COVERED = 2'd1,
    CAUSE_SCANS   = 2'd2
  } cause_t;

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [11:0] b);
    logic [BIN_W-1:0] r;
    if (32'(b) >= 32'(BIN_COUNT)) begin
      r = BIN_W'(BIN_COUNT - 1);
    end else begin
      r = BIN_W'(b);
    end
    return r;
  endfunction

  function automatic logic [BIN_W-1:0] angle_to_bin(input logic [15:0] angle);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(angle) * PROD_W'(ANGLE_SCALE) + PROD_W'(1 << (FRAC_BITS - 1));
    return clamp_bin(prod[PROD_W-1:FRAC_BITS]);
  endfunction

endpackage

### src/angle_bin_min_distance_capture_unit.sv
// A result passes the update stage and then the output register, and waits
//   in the update stage while the output still holds an untaken result.
// An interlock holds a new item until the update stage has written its bin
//   (read at accept, write in the update stage), so an item is through
//   before the next is taken; an untaken result at the output stalls the input.
// Reset (rst, synchronous, active high) clears counters and control, then a
//   clearing pass writes "no reading" to all 3600 bins, one per cycle;
//   no item is accepted until the pass ends. Configuration is taken outside reset.
`include "assert_macros.svh"

module angle_bin_min_distance_capture_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: scan limit
  input  logic                          cfg_we,
  input  logic [15:0]                   cfg_wdata,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [15:0]                   angle_q14,
  input  logic [31:0]                   dist_q2,
  input  logic [7:0]                    quality_raw,
  input  logic [11:0]                   read_bin,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [11:0]                   bin,
  output logic [abmdc_pkg::DIST_W-1:0]  distance_mm,
  output logic                          improved,
  output logic [11:0]                   covered_count,
  output logic                          finished,
  output logic [1:0]                    finish_cause
);
  import abmdc_pkg::*;

  // Bin minimum store: one read at accept, one write in the update stage
  logic [DIST_W-1:0] mem [BIN_COUNT];
  logic [DIST_W-1:0] rd_data;
  logic [BIN_W-1:0]  rd_addr;
  logic              mem_we;
  logic [BIN_W-1:0]  wr_addr;
  logic [DIST_W-1:0] wr_data;

  // Clearing pass after reset
  logic              clearing;
  logic [BIN_W-1:0]  clear_addr;

  // Configuration and running state
  logic [15:0]       scan_limit;
  logic [CNT_W-1:0]  covered;
  logic [CNT_W-1:0]  covered_next;
  logic [15:0]       scans;
  logic [15:0]       scans_next;
  cause_t            stop_cause;
  cause_t            stop_cause_next;

  // Update stage: item held while its bin is read
  logic              b_valid;
  func_t             b_func;
  logic [BIN_W-1:0]  b_bin;
  logic [31:0]       b_dist_q2;
  logic              b_qual_ok;
  logic              b_fire;
  logic              in_fire;

  // Result of the update stage
  logic              improve;
  logic [DIST_W-1:0] new_min;
  logic [BIN_W-1:0]  res_bin;
  logic [DIST_W-1:0] res_dist;

  // Take a new item only when the update stage is empty, so the bin it reads
  // already holds any write of the item before it: no forwarding path needed.
  assign in_ready = !clearing && !b_valid;
  assign in_fire  = in_valid && in_ready;
  assign b_fire   = b_valid && (!out_valid || out_ready);

  // Address of the bin read at accept: a read item names it, others bin the angle
  always_comb begin
    if (func_t'(func) == FUNC_READ) begin
      rd_addr = clamp_bin(read_bin);
    end else begin
      rd_addr = angle_to_bin(angle_q14);
    end
  end

  // Memory port: the clearing pass owns the write side until it ends
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    mem_we  = clearing || (b_fire && improve);
    wr_addr = clearing ? clear_addr : b_bin;
    wr_data = clearing ? NO_READING : new_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == BIN_W'(BIN_COUNT - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= SCAN_LIMIT_RST;
    end else if (cfg_we) begin
      scan_limit <= cfg_wdata;
    end
  end

  // Capture the item into the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_fire) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_func    <= func_t'(func);
      b_bin     <= rd_addr;
      b_dist_q2 <= dist_q2;
      b_qual_ok <= (quality_raw >> QUALITY_SHIFT) != 8'd0;
    end
  end

  // Update stage: compare against the stored minimum, count coverage and scans.
  // While running, a good-quality reading improves if its quarter-mm distance < 4x the stored mm.
  always_comb begin
    new_min         = {1'b0, b_dist_q2[31:2]};
    improve         = 1'b0;
    res_bin         = '0;
    res_dist        = '0;
    covered_next    = covered;
    scans_next      = scans;
    stop_cause_next = stop_cause;
    unique case (b_func)
      FUNC_MEAS: begin
        res_bin = b_bin;
        if (stop_cause == CAUSE_RUNNING && b_qual_ok &&
            ({1'b0, b_dist_q2} < {rd_data, 2'b00})) begin
          improve = 1'b1;
        end
        res_dist = improve ? new_min : rd_data;
        // First reading of a bin covers it; all bins covered ends the run
        if (improve && rd_data == NO_READING) begin
          covered_next = covered + 1'b1;
          if (covered_next == CNT_W'(BIN_COUNT)) begin
            stop_cause_next = CAUSE_COVERED;
          end
        end
      end
      FUNC_SCAN: begin
        if (stop_cause == CAUSE_RUNNING) begin
          if (scans > scan_limit) begin
            stop_cause_next = CAUSE_SCANS;
          end
          if (scans != SCANS_MAX) begin
            scans_next = scans + 1'b1;
          end
        end
      end
      FUNC_READ: begin
        res_bin  = b_bin;
        res_dist = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      covered    <= '0;
      scans      <= '0;
      stop_cause <= CAUSE_RUNNING;
    end else if (b_fire) begin
      covered    <= covered_next;
      scans      <= scans_next;
      stop_cause <= stop_cause_next;
    end
  end

  // Output register: holds the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      bin           <= 12'(res_bin);
      distance_mm   <= res_dist;
      improved      <= improve;
      covered_count <= 12'(covered_next);
      finished      <= stop_cause_next != CAUSE_RUNNING;
      finish_cause  <= stop_cause_next;
    end
  end

  // No item enters while the bins are being cleared
  `ASSERT_ALL(a_no_accept_clearing, clk, clearing |-> !in_ready)
  // A finished run stays finished with the same cause
  `ASSERT_RST(a_stop_sticky, clk, rst,
    (stop_cause != CAUSE_RUNNING) |=> (stop_cause == $past(stop_cause)))
  // Coverage never runs past the number of bins
  `ASSERT_RST(a_cover_bound, clk, rst, covered <= CNT_W'(BIN_COUNT))
  // Once finished, only the clearing pass writes the store
  `ASSERT_RST(a_no_write_finished, clk, rst,
    (stop_cause != CAUSE_RUNNING && mem_we) |-> clearing)

endmodule

### test/angle_bin_min_distance_capture_checker.sv
`timescale 1ns / 1ps

module angle_bin_min_distance_capture_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [15:0]                  cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [15:0]                  angle_q14,
  input  logic [31:0]                  dist_q2,
  input  logic [7:0]                   quality_raw,
  input  logic [11:0]                  read_bin,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [11:0]                  bin,
  input  logic [abmdc_pkg::DIST_W-1:0] distance_mm,
  input  logic                         improved,
  input  logic [11:0]                  covered_count,
  input  logic                         finished,
  input  logic [1:0]                   finish_cause,
  output int                           mismatches,
  output int                           outstanding
);
  import abmdc_pkg::*;

  typedef struct packed {
    logic [11:0]       bin;
    logic [DIST_W-1:0] distance;
    logic              improved;
    logic [11:0]       covered;
    logic              finished;
    logic [1:0]        cause;
  } capture_result_t;

  logic [DIST_W-1:0] bin_floor [BIN_COUNT];
  int unsigned       covered_total;
  logic [15:0]       scans_seen;
  cause_t            stop_cause;
  logic [15:0]       scan_limit;
  capture_result_t   awaited_results [$];

  function automatic logic [11:0] limit_bin(input int unsigned b);
    return (b >= BIN_COUNT) ? 12'(BIN_COUNT - 1) : 12'(b);
  endfunction

  // Update the bin store and counters for one item and return what it shows.
  function automatic capture_result_t capture_outcome(input func_t op,
      input logic [15:0] angle, input logic [31:0] dq2, input logic [7:0] qual,
      input logic [11:0] rsel);
    capture_result_t r;
    logic [DIST_W-1:0] held;
    r = '0;
    case (op)
      FUNC_MEAS: begin
        r.bin = limit_bin((32'(angle) * 900 + 8192) >> 14);
        held  = bin_floor[r.bin];
        if (stop_cause == CAUSE_RUNNING && (qual >> QUALITY_SHIFT) != 0 &&
            {1'b0, dq2} < {held, 2'b00}) begin
          bin_floor[r.bin] = DIST_W'(dq2[31:2]);
          r.improved = 1'b1;
          if (held == NO_READING) begin
            covered_total++;
            if (covered_total == BIN_COUNT) stop_cause = CAUSE_COVERED;
          end
        end
        r.distance = bin_floor[r.bin];
      end
      FUNC_SCAN: begin
        if (stop_cause == CAUSE_RUNNING) begin
          if (scans_seen > scan_limit) stop_cause = CAUSE_SCANS;
          if (scans_seen != SCANS_MAX) scans_seen++;
        end
      end
      FUNC_READ: begin
        r.bin      = limit_bin(rsel);
        r.distance = bin_floor[r.bin];
      end
      default: ;
    endcase
    r.covered  = covered_total[11:0];
    r.finished = (stop_cause != CAUSE_RUNNING);
    r.cause    = stop_cause;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    capture_result_t want;
    if (rst) begin
      for (int i = 0; i < BIN_COUNT; i++) bin_floor[i] = NO_READING;
      covered_total = 0;
      scans_seen    = '0;
      stop_cause    = CAUSE_RUNNING;
      scan_limit    = SCAN_LIMIT_RST;
      awaited_results.delete();
    end else begin
      if (cfg_we) scan_limit = cfg_wdata;
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result item with nothing expected, bin %0d", $time, bin);
        end else begin
          want = awaited_results.pop_front();
          check_field("bin", 32'(want.bin), 32'(bin));
          check_field("distance_mm", 32'(want.distance), 32'(distance_mm));
          check_field("improved", 32'(want.improved), 32'(improved));
          check_field("covered_count", 32'(want.covered), 32'(covered_count));
          check_field("finished", 32'(want.finished), 32'(finished));
          check_field("finish_cause", 32'(want.cause), 32'(finish_cause));
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(capture_outcome(func_t'(func), angle_q14, dist_q2,
                                                  quality_raw, read_bin));
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

### test/angle_bin_min_distance_capture_unit_test.sv
`timescale 1ns / 1ps

module angle_bin_min_distance_capture_unit_test;
  import abmdc_pkg::*;

  // Slowest correct run: reset plus the clearing pass, then some six hundred
  // items with sender gaps, drains and receiver stalls, stays well under the
  // limit set here.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int FIRST_HALF  = 250;
  localparam int SECOND_HALF = 250;
  localparam int AFTER_STOP  = 30;

  typedef struct {
    func_t       op;
    logic [15:0] angle;
    logic [31:0] dq2;
    logic [7:0]  qual;
    logic [11:0] rsel;
  } capture_item_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_we      = 1'b0;
  logic [15:0]           cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [1:0]            func        = '0;
  logic [15:0]           angle_q14   = '0;
  logic [31:0]           dist_q2     = '0;
  logic [7:0]            quality_raw = '0;
  logic [11:0]           read_bin    = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [11:0]           bin;
  logic [DIST_W-1:0]     distance_mm;
  logic                  improved;
  logic [11:0]           covered_count;
  logic                  finished;
  logic [1:0]            finish_cause;
  int                    mismatches;
  int                    outstanding;

  // Bins that measurements and reads keep returning to, so that minima get
  // lowered, re-read and compared against repeatedly.
  logic [11:0]           hot_bins [8];
  int unsigned           scans_sent  = 0;
  int unsigned           cycle_count = 0;
  int unsigned           ready_run   = 0;
  int unsigned           stall_run   = 0;

  angle_bin_min_distance_capture_unit dut (.*);

  angle_bin_min_distance_capture_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("angle_bin_min_distance_capture_unit: mismatch");
      $finish;
    end
  end

  // Receiver: runs of ready followed by short stalls; a third of the runs
  // carry no stall at all, giving long stretches at full rate.
  always @(negedge clk) begin
    if (ready_run != 0) begin
      out_ready = 1'b1;
      ready_run--;
    end else if (stall_run != 0) begin
      out_ready = 1'b0;
      stall_run--;
    end else begin
      ready_run = $urandom_range(1, 24);
      stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      out_ready = 1'b1;
    end
  end

  function automatic capture_item_t make_item(input func_t op, input int unsigned a,
      input int unsigned d, input int unsigned q, input int unsigned r);
    capture_item_t it;
    it.op    = op;
    it.angle = 16'(a);
    it.dq2   = d;
    it.qual  = 8'(q);
    it.rsel  = 12'(r);
    return it;
  endfunction

  // Pick an angle that lands in or right beside the given bin.
  function automatic logic [15:0] angle_near(input logic [11:0] b);
    int a;
    a = (int'(b) * 16384 + 450) / 900 + int'($urandom_range(0, 8)) - 4;
    if (a < 0) a = 0;
    if (a > 65535) a = 65535;
    return 16'(a);
  endfunction

  // Measurements on the hot bins with small distances, so that minima fall
  // step by step, plus scan_pct percent end-of-scan items, reads and no-ops.
  function automatic capture_item_t random_item(input int unsigned scan_pct);
    capture_item_t it;
    int unsigned   pick;
    it = make_item(FUNC_MEAS, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 19) == 0)
      hot_bins[$urandom_range(0, 7)] = 12'($urandom_range(0, BIN_COUNT - 1));
    pick = $urandom_range(0, 99);
    if (pick < scan_pct) it.op = FUNC_SCAN;
    else if (pick < scan_pct + 20) it.op = FUNC_READ;
    else if (pick < scan_pct + 28) it.op = FUNC_NOP;
    if (it.op == FUNC_MEAS) begin
      if ($urandom_range(0, 4) != 0) it.angle = angle_near(hot_bins[$urandom_range(0, 7)]);
      case ($urandom_range(0, 9))
        0, 1, 2:    ;
        3, 4, 5, 6: it.dq2 = $urandom_range(0, 4000);
        default:    it.dq2 = $urandom_range(0, 400);
      endcase
      // a fifth of the readings fall below the quality threshold
      it.qual = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 3))
                                             : 8'($urandom_range(4, 255));
    end else if (it.op == FUNC_READ && $urandom_range(0, 2) != 0) begin
      it.rsel = hot_bins[$urandom_range(0, 7)];
    end
    return it;
  endfunction

  // Present one item at the falling edge and hold it until it is taken.
  task automatic drive_item(input capture_item_t it);
    @(negedge clk);
    in_valid    = 1'b1;
    func        = it.op;
    angle_q14   = it.angle;
    dist_q2     = it.dq2;
    quality_raw = it.qual;
    read_bin    = it.rsel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.op == FUNC_SCAN) scans_sent++;
  endtask

  task automatic idle_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_scan_limit(input logic [15:0] value);
    drain_results();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Bursts of random length with random gaps; now and then a burst waits
  // for the block to empty completely first.
  task automatic send_stream(input int count, input int unsigned scan_pct);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 14) == 0) drain_results();
        else idle_sender($urandom_range(0, 6));
      end
      drive_item(random_item(scan_pct));
      burst--;
    end
  endtask

  initial begin
    int unsigned   limit_value;
    int unsigned   scans_needed;
    int unsigned   phase_scans;
    capture_item_t it;

    for (int i = 0; i < 8; i++) hot_bins[i] = 12'($urandom_range(0, BIN_COUNT - 1));
    hot_bins[0] = '0;
    hot_bins[1] = 12'(BIN_COUNT - 1);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, under the reset scan limit. Reads of empty bins and
    // out-of-range bin selects first.
    drive_item(make_item(FUNC_READ, 0, 0, 0, 0));
    drive_item(make_item(FUNC_READ, 0, 0, 0, 4095));
    drive_item(make_item(FUNC_READ, 0, 0, 0, BIN_COUNT));
    // Zero distance at angle zero, then a larger one that must not improve
    // at the lowest quality that still counts.
    drive_item(make_item(FUNC_MEAS, 0, 0, 255, 0));
    drive_item(make_item(FUNC_MEAS, 0, 3, 4, 0));
    // Largest distance at the largest angle (clamped to the last bin), then
    // one exactly equal to four times the stored value, then one below it.
    drive_item(make_item(FUNC_MEAS, 65535, 32'hFFFF_FFFF, 255, 0));
    drive_item(make_item(FUNC_MEAS, 65527, 32'hFFFF_FFFC, 255, 0));
    drive_item(make_item(FUNC_MEAS, 65527, 32'hFFFF_FFFB, 128, 0));
    // Low quality changes nothing; half-way angles round up.
    drive_item(make_item(FUNC_MEAS, 2048, 1000, 3, 0));
    drive_item(make_item(FUNC_MEAS, 2048, 1000, 4, 0));
    drive_item(make_item(FUNC_MEAS, 2047, 999, 255, 0));
    drive_item(make_item(FUNC_MEAS, 6144, 77, 255, 0));
    drive_item(make_item(FUNC_MEAS, 2048, 1001, 255, 0));
    drive_item(make_item(FUNC_MEAS, 2048, 999, 255, 0));
    // End of scan and no-op with every field at both extremes.
    drive_item(make_item(FUNC_SCAN, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 12'hFFF));
    drive_item(make_item(FUNC_NOP, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 12'hFFF));
    drive_item(make_item(FUNC_NOP, 0, 0, 0, 0));
    drive_item(make_item(FUNC_SCAN, 0, 0, 0, 0));
    drive_item(make_item(FUNC_READ, 0, 0, 0, 113));
    drive_item(make_item(FUNC_READ, 0, 0, 0, BIN_COUNT - 1));
    drive_item(make_item(FUNC_READ, 0, 0, 0, 338));

    // Random part, at a limit that cannot be passed.
    write_scan_limit(SCANS_MAX);
    send_stream(FIRST_HALF, 10);
    write_scan_limit(16'($urandom_range(scans_sent + SECOND_HALF + 2, 65534)));
    send_stream(SECOND_HALF, 10);

    // Close the run by passing the scan limit: a limit of zero or at most three above
    // the scans so far, then enough scans to pass it, mixed with other items.
    limit_value  = ($urandom_range(0, 1) == 0) ? 0 : scans_sent + $urandom_range(0, 3);
    scans_needed = (limit_value >= scans_sent) ? limit_value - scans_sent + 4 : 3;
    write_scan_limit(16'(limit_value));
    phase_scans = 0;
    while (phase_scans < scans_needed) begin
      it = random_item(50);
      if (it.op == FUNC_SCAN) phase_scans++;
      drive_item(it);
    end

    // Once stopped, measurements and scans must leave everything alone.
    send_stream(AFTER_STOP, 25);

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("angle_bin_min_distance_capture_unit: match");
    end else begin
      $display("angle_bin_min_distance_capture_unit: mismatch");
    end
    $finish;
  end

endmodule
